### sv/bqiir_pkg.sv
package bqiir_pkg;

  // Field widths fixed by the stream format
  localparam int CH_W      = 3;
  localparam int COEF_W    = 16;
  localparam int X_W       = 16;
  localparam int ACC_W     = 32;
  localparam int DIV_SHIFT = 14;                  // divide by 16384
  localparam int Y_W       = ACC_W - DIV_SHIFT;   // quotient always fits here
  localparam int FILT_W    = 16;

  localparam int CHANNELS_DEF = 6;
  localparam int ADC_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;

  localparam logic signed [COEF_W-1:0] A0_RST = 16'sd9098;
  localparam logic signed [COEF_W-1:0] A1_RST = 16'sd18197;
  localparam logic signed [COEF_W-1:0] A2_RST = 16'sd9098;
  localparam logic signed [COEF_W-1:0] B1_RST = 16'sd15579;
  localparam logic signed [COEF_W-1:0] B2_RST = 16'sd4430;

  // Rounding bias so that an arithmetic shift truncates toward zero
  localparam logic signed [ACC_W-1:0] DIV_BIAS = (ACC_W)'((1 << DIV_SHIFT) - 1);

endpackage

### sv/six_channel_biquad_iir_filter.sv
// Six-channel biquad (direct form I) filter for raw ADC samples.
//
// Input stream s_*: one transaction = one ADC sample and its channel number.
// The mid-scale offset is removed, the channel's biquad is run with the five
// shared coefficients, the offset is added back and the result leaves on m_*
// with the channel echoed. A channel number at or above CHANNELS gives a
// result of zero and leaves every history untouched.
//
// Path: the transaction loads the input register; the output register is then
// loaded, when free, after five parallel multipliers, the sum and the
// truncating shift.
// Throughput: one sample per cycle while m_tready is high, also for
// back-to-back samples of one channel; a channel's feedback y1/y2 is written
// in the cycle its result is registered, so the next sample sees it at once.
//
// Stall: when m_tready is low the result holds in the output register; the
// input register still takes one more transaction, then s_tready drops.
// Reset (rst, synchronous): coefficients return to their default low-pass
// set, all channel histories clear to zero, both registers empty.
// Write coefficients through cfg_* only while the stream is idle (unenforced).
module six_channel_biquad_iir_filter
  import bqiir_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF,
  localparam int IN_W    = ((CH_W + ADC_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((CH_W + FILT_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_W-1:0]          s_tdata,   // channel, sample, zero pad
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata,   // channel_out, filtered, zero pad
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OFFSET   = (1 << ADC_BITS) / 2;

  // Coefficient registers
  logic signed [COEF_W-1:0] coef_a0, coef_a1, coef_a2, coef_b1, coef_b2;

  // Per-channel history
  logic signed [X_W-1:0] x1_hist [CHANNELS];
  logic signed [X_W-1:0] x2_hist [CHANNELS];
  logic signed [Y_W-1:0] y1_hist [CHANNELS];
  logic signed [Y_W-1:0] y2_hist [CHANNELS];

  // Input register
  logic                st_valid;
  logic [CH_W-1:0]     st_channel;
  logic [ADC_BITS-1:0] st_sample;

  // Output register
  logic [CH_W-1:0]   out_channel;
  logic [FILT_W-1:0] out_filtered;

  logic advance;
  logic in_range;
  logic [IDX_W-1:0] idx;

  logic [X_W:0]            diff;
  logic signed [X_W-1:0]   x0;
  logic signed [ACC_W-1:0] p0, p1, p2;
  logic signed [COEF_W+Y_W-1:0] p3, p4;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [Y_W-1:0]   y0;
  logic [Y_W-1:0]          y_off;
  logic [FILT_W-1:0]       filtered_next;

  assign advance  = st_valid && (!m_tvalid || m_tready);
  assign s_tready = !st_valid || advance;

  assign in_range = (int'(st_channel) < CHANNELS);
  assign idx      = IDX_W'(st_channel);

  // Datapath: one pass from the input register to the output register
  always_comb begin
    diff    = (X_W + 1)'(st_sample) - (X_W + 1)'(OFFSET);
    x0      = signed'(diff[X_W-1:0]);
    p0      = ACC_W'(coef_a0) * ACC_W'(x0);
    p1      = ACC_W'(coef_a1) * ACC_W'(x1_hist[idx]);
    p2      = ACC_W'(coef_a2) * ACC_W'(x2_hist[idx]);
    p3      = (COEF_W + Y_W)'(coef_b1) * (COEF_W + Y_W)'(y1_hist[idx]);
    p4      = (COEF_W + Y_W)'(coef_b2) * (COEF_W + Y_W)'(y2_hist[idx]);
    // sum wraps mod 2^32
    acc     = p0 + p1 + p2 - signed'(p3[ACC_W-1:0]) - signed'(p4[ACC_W-1:0]);
    // negative sums get a bias so the shift truncates toward zero
    acc_adj = acc + (acc[ACC_W-1] ? DIV_BIAS : '0);
    y0      = signed'(acc_adj[ACC_W-1:DIV_SHIFT]);
    y_off   = y0 + Y_W'(OFFSET);
    filtered_next = in_range ? y_off[FILT_W-1:0] : '0;
  end

  // Coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0 <= A0_RST;
      coef_a1 <= A1_RST;
      coef_a2 <= A2_RST;
      coef_b1 <= B1_RST;
      coef_b2 <= B2_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A0:  coef_a0 <= signed'(cfg_data);
        REG_A1:  coef_a1 <= signed'(cfg_data);
        REG_A2:  coef_a2 <= signed'(cfg_data);
        REG_B1:  coef_b1 <= signed'(cfg_data);
        REG_B2:  coef_b2 <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // History update, in the same cycle the result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_hist[i] <= '0;
        x2_hist[i] <= '0;
        y1_hist[i] <= '0;
        y2_hist[i] <= '0;
      end
    end else if (advance && in_range) begin
      x1_hist[idx] <= x0;
      x2_hist[idx] <= x1_hist[idx];
      y1_hist[idx] <= y0;
      y2_hist[idx] <= y1_hist[idx];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_channel <= s_tdata[CH_W-1:0];
      st_sample  <= s_tdata[CH_W +: ADC_BITS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel  <= st_channel;
      out_filtered <= filtered_next;
    end
  end

  assign m_tdata = OUT_W'({out_filtered, out_channel});

endmodule

### bench/tb_six_channel_biquad_iir_filter.sv
module tb_six_channel_biquad_iir_filter;
  import bqiir_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS  = CHANNELS_DEF;
  localparam int S_W       = 16;              // 3 + 12 bits, padded to 2 bytes
  localparam int M_W       = 24;              // 3 + 16 bits, padded to 3 bytes
  localparam int PHASE_LEN = 178;
  localparam int N_SETS    = 8;
  localparam int LIMIT     = 1_000_000;       // cycles

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [11:0]     sample;
  } adc_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [FILT_W-1:0] filt;
  } filt_word_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata = '0;               // channel, sample, zero pad
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;                    // channel_out, filtered, zero pad
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  six_channel_biquad_iir_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Local filter model: shared coefficients, per-channel history
  // ---------------------------------------------------------------------
  logic signed [COEF_W-1:0] k_a0 = A0_RST, k_a1 = A1_RST, k_a2 = A2_RST;
  logic signed [COEF_W-1:0] k_b1 = B1_RST, k_b2 = B2_RST;
  logic signed [X_W-1:0]    x_one [CHANNELS];
  logic signed [X_W-1:0]    x_two [CHANNELS];
  logic signed [ACC_W-1:0]  y_one [CHANNELS];
  logic signed [ACC_W-1:0]  y_two [CHANNELS];

  adc_word_t  samples_to_send[$];
  filt_word_t results_due[$];

  int fails = 0;
  int n_results = 0;
  int n_unused_ch = 0;
  int n_sets = 1;
  int cycles = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      x_one[c] = '0;
      x_two[c] = '0;
      y_one[c] = '0;
      y_two[c] = '0;
    end
  end

  // One sample through the channel's biquad; updates history.
  function automatic filt_word_t biquad_step(logic [CH_W-1:0] ch, logic [11:0] smp);
    filt_word_t              r;
    logic signed [X_W-1:0]   x0;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] outv;
    r.ch   = ch;
    r.filt = '0;
    if (ch < CHANNELS) begin
      x0  = $signed({4'b0000, smp}) - 16'sd2048;
      // all terms sign-extended to 32 bits, sum wraps mod 2^32
      acc = ACC_W'(k_a0) * ACC_W'(x0) + ACC_W'(k_a1) * ACC_W'(x_one[ch])
          + ACC_W'(k_a2) * ACC_W'(x_two[ch])
          - ACC_W'(k_b1) * y_one[ch] - ACC_W'(k_b2) * y_two[ch];
      q   = acc / 32'sd16384;                 // truncates toward zero
      x_two[ch] = x_one[ch];
      x_one[ch] = x0;
      y_two[ch] = y_one[ch];
      y_one[ch] = q;
      outv   = q + 32'sd2048;
      r.filt = outv[FILT_W-1:0];
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones; calm stretches have none.
  function automatic int pick_gap(logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: feeds queued samples, predicts at each accepted transaction
  // ---------------------------------------------------------------------
  int        send_gap = 0;
  logic      send_calm = 1'b0;
  adc_word_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        results_due.push_back(biquad_step(s_tdata[2:0], s_tdata[14:3]));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          nxt = samples_to_send.pop_front();
          s_tdata  <= {1'b0, nxt.sample, nxt.ch};
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
          send_gap = pick_gap(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random backpressure, in-order compare
  // ---------------------------------------------------------------------
  int         stall = 0;
  logic       recv_calm = 1'b0;
  filt_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result with nothing expected: channel_out %0d filtered %0d",
                 m_tdata[2:0], m_tdata[18:3]);
          fails++;
        end else begin
          want = results_due.pop_front();
          n_results++;
          if (want.ch >= CHANNELS) n_unused_ch++;
          if (m_tdata[2:0] !== want.ch) begin
            $error("channel_out: expected %0d, got %0d", want.ch, m_tdata[2:0]);
            fails++;
          end
          if (m_tdata[18:3] !== want.filt) begin
            $error("filtered: expected %0d, got %0d", want.filt, m_tdata[18:3]);
            fails++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
        if ($urandom_range(0, 3) == 0) stall = pick_gap(recv_calm);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_sample(logic [CH_W-1:0] ch, logic [11:0] smp);
    adc_word_t w;
    w.ch     = ch;
    w.sample = smp;
    samples_to_send.push_back(w);
  endtask

  // Mostly valid channels; samples lean toward the rails now and then.
  task automatic queue_random_sample();
    logic [CH_W-1:0] ch;
    logic [11:0]     smp;
    int              r;
    ch  = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(CHANNELS, 7))
                                      : CH_W'($urandom_range(0, CHANNELS - 1));
    r   = $urandom_range(0, 19);
    smp = (r == 0) ? 12'h000 : (r == 1) ? 12'hfff : 12'($urandom);
    queue_sample(ch, smp);
  endtask

  // Stream drained, nothing outstanding, then the pipeline's latency.
  task automatic wait_idle();
    @(negedge clk);
    while (samples_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_A0:  k_a0 = val;
      REG_A1:  k_a1 = val;
      REG_A2:  k_a2 = val;
      REG_B1:  k_b1 = val;
      REG_B2:  k_b2 = val;
      default: ;                             // unmapped index, ignored
    endcase
  endtask

  // Full coefficient set plus junk writes to the unmapped indexes.
  task automatic load_coefs(logic [COEF_W-1:0] a0, logic [COEF_W-1:0] a1,
                            logic [COEF_W-1:0] a2, logic [COEF_W-1:0] b1,
                            logic [COEF_W-1:0] b2);
    write_reg(REG_A0, a0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    for (int k = REG_B2 + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), COEF_W'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_sets++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: rails, mid-scale, bit patterns, every channel incl. unused,
    // consecutive samples on one channel, default coefficients
    for (int c = 0; c < 8; c++) queue_sample(CH_W'(c), (c % 2) ? 12'hfff : 12'h000);
    queue_sample(3'd0, 12'd2048);
    queue_sample(3'd0, 12'd2047);
    queue_sample(3'd0, 12'd2049);
    queue_sample(3'd0, 12'd1);
    queue_sample(3'd1, 12'haaa);
    queue_sample(3'd1, 12'h555);
    queue_sample(3'd6, 12'haaa);
    queue_sample(3'd7, 12'h555);
    queue_sample(3'd5, 12'hfff);
    queue_sample(3'd5, 12'hfff);
    queue_sample(3'd5, 12'h000);
    queue_sample(3'd2, 12'h800);
    wait_idle();

    // Random phases, one coefficient set each
    for (int p = 0; p < N_SETS; p++) begin
      case (p)
        0: ;                                         // defaults from reset
        1: load_coefs(16'sd16384, '0, '0, '0, '0);   // x passes straight through
        // positive rails forward, negative rails in feedback: sum overflows
        2: load_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        3: load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        7: load_coefs(A0_RST, A1_RST, A2_RST, B1_RST, B2_RST);
        default: load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                            COEF_W'($urandom), COEF_W'($urandom));
      endcase
      for (int k = 0; k < PHASE_LEN; k++) begin
        queue_random_sample();
        // in odd phases the sender holds off mid-phase until every result is back
        if (k == PHASE_LEN / 2 && p % 2 == 1) wait_idle();
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fails++;
    end
    $display("Covered %0d filtered results (%0d on unused channels) over %0d coefficient sets,",
             n_results, n_unused_ch, n_sets);
    $display("including rail coefficients with accumulator wrap and random backpressure.");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### six_channel_biquad_iir_filter.f
sv/bqiir_pkg.sv
sv/six_channel_biquad_iir_filter.sv
bench/tb_six_channel_biquad_iir_filter.sv
